### hdl/sparse_block_map_translator_assert.svh
// Assertion macros used by the translator RTL file.
`ifndef SPARSE_BLOCK_MAP_TRANSLATOR_ASSERT_SVH
`define SPARSE_BLOCK_MAP_TRANSLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBMT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sbmt_pkg.sv
package sbmt_pkg;

  localparam int unsigned BS_W       = 25;
  localparam int unsigned ADDR_W     = 40;
  localparam int unsigned SUM_W      = ADDR_W + 1;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned SIDX_W     = 15;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned DIV_CNT_W  = $clog2(ADDR_W + 1);
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [BS_W-1:0]   RESET_BLOCK_SIZE = 25'd2097152;
  localparam logic [BYTE_W-1:0] MAP_STORED_BYTE  = 8'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_BLOCK_SIZE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SPAN  = 2'd2
  } status_e;

endpackage

### hdl/sparse_block_map_translator.sv
// Load item: taken while idle, gives no result; the next item can follow at once.
// Read item, blocking new items until done: range check (S_MUL, S_CHK), a restoring
// divider for block number and in-block offset (S_DIV), span check (S_SPAN), then per
// segment map memory read, multiply, add (S_RD, S_PROD, S_OUT); zero length ends at S_CHK.
// Reset clears the control state, the load counters and sets block_size to 2097152;
// the map memory is not cleared and must be fully loaded before reads.
module sparse_block_map_translator #(
  parameter int unsigned MAP_ENTRIES  = 32760,
  parameter int unsigned HEADER_BYTES = 32768,
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbmt_pkg::PADDR_W-1:0]        paddr,
  input  logic [sbmt_pkg::PDATA_W-1:0]        pwdata,
  output logic [sbmt_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [sbmt_pkg::BYTE_W-1:0]         map_byte_i,
  input  logic [sbmt_pkg::ADDR_W-1:0]         read_offset_i,
  input  logic [sbmt_pkg::ADDR_W-1:0]         read_length_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sbmt_pkg::STATUS_W-1:0]       status_o,
  output logic                                zero_fill_o,
  output logic [sbmt_pkg::ADDR_W-1:0]         file_offset_o,
  output logic [sbmt_pkg::BS_W-1:0]           segment_length_o,
  output logic                                last_o
);
  import sbmt_pkg::*;

  localparam int unsigned IDX_W  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int unsigned LCNT_W = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned LIM_W  = BS_W + $clog2(MAX_SEGMENTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_SPAN = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_PROD = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]           state_q, state_d;
  logic [BS_W-1:0]      bs_q;
  logic [LCNT_W-1:0]    load_idx_q;
  logic [SIDX_W-1:0]    stored_cnt_q;
  logic [ENTRY_W-1:0]   mem_q [MAP_ENTRIES];
  logic [ENTRY_W-1:0]   rd_q;

  logic [ADDR_W-1:0]    off_q, len_q, rem_len_q;
  logic [SUM_W-1:0]     dsize_q, sum_q;
  logic [LIM_W-1:0]     lim_q;
  logic [BS_W-1:0]      rem_q;
  logic [ADDR_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0]     blk_q;
  logic [ADDR_W-1:0]    prod_q, base_q;
  logic                 stored_q;
  logic [BS_W-1:0]      seg_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 zero_fill_q, last_q;
  logic [ADDR_W-1:0]    file_offset_q;
  logic [BS_W-1:0]      seg_len_q;

  logic                 in_acc, cfg_wr, load_wr, out_free, out_load;
  logic [BS_W:0]        div_shl, div_diff;
  logic                 div_ge;
  logic [SUM_W-1:0]     span_end;
  logic                 span_err, seg_last;
  logic [BS_W-1:0]      room;
  logic [STATUS_W-1:0]  res_status;
  logic                 res_zero_fill;
  logic [ADDR_W-1:0]    res_file_offset;
  logic [BS_W-1:0]      res_seg_len;
  logic [ADDR_W-1:0]    prod_d;
  logic [SUM_W-1:0]     dsize_d;
  logic [LIM_W-1:0]     lim_d;

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_BLOCK_SIZE) ? PDATA_W'(bs_q) : '0;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SIZE);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_wr    = in_acc && (opcode_i == OP_LOAD) && (load_idx_q < LCNT_W'(MAP_ENTRIES));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign div_shl    = {rem_q, quo_q[ADDR_W-1]};
  assign div_ge     = (div_shl >= {1'b0, bs_q});
  assign div_diff   = div_shl - {1'b0, bs_q};

  assign span_end   = SUM_W'(rem_q) + {1'b0, len_q} - SUM_W'(1);
  assign span_err   = (span_end >= SUM_W'(lim_q));
  assign room       = bs_q - rem_q;
  assign seg_last   = (rem_len_q == ADDR_W'(seg_q));

  assign prod_d     = ADDR_W'(rd_q[SIDX_W-1:0]) * ADDR_W'(bs_q);
  assign dsize_d    = SUM_W'(MAP_ENTRIES) * SUM_W'(bs_q);
  assign lim_d      = LIM_W'(MAX_SEGMENTS) * LIM_W'(bs_q);

  always_comb begin
    state_d         = state_q;
    out_load        = 1'b0;
    res_status      = ST_OK;
    res_zero_fill   = 1'b0;
    res_file_offset = '0;
    res_seg_len     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (opcode_i == OP_READ)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sum_q > dsize_q) begin
          res_status = ST_RANGE;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (len_q == '0) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_q == DIV_CNT_W'(ADDR_W - 1)) begin
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        if (span_err) begin
          res_status = ST_SPAN;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_PROD;
      end
      S_PROD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        res_zero_fill   = !stored_q;
        res_file_offset = stored_q ? (prod_q + base_q) : '0;
        res_seg_len     = seg_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = seg_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bs_q         <= RESET_BLOCK_SIZE;
      load_idx_q   <= '0;
      stored_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        bs_q <= pwdata[BS_W-1:0];
      end
      if (load_wr) begin
        load_idx_q <= load_idx_q + LCNT_W'(1);
        if (map_byte_i == MAP_STORED_BYTE) begin
          stored_cnt_q <= stored_cnt_q + SIDX_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      mem_q[load_idx_q[IDX_W-1:0]] <= (map_byte_i == MAP_STORED_BYTE) ?
                                      {1'b1, stored_cnt_q} : '0;
    end
    rd_q <= mem_q[blk_q];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        off_q <= read_offset_i;
        len_q <= read_length_i;
      end
      S_MUL: begin
        dsize_q <= dsize_d;
        lim_q   <= lim_d;
        sum_q   <= {1'b0, off_q} + {1'b0, len_q};
      end
      S_CHK: begin
        rem_q <= '0;
        quo_q <= off_q;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_diff[BS_W-1:0] : div_shl[BS_W-1:0];
        quo_q <= {quo_q[ADDR_W-2:0], div_ge};
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
      S_SPAN: begin
        blk_q     <= quo_q[IDX_W-1:0];
        rem_len_q <= len_q;
      end
      S_PROD: begin
        prod_q   <= prod_d;
        stored_q <= rd_q[ENTRY_W-1];
        base_q   <= ADDR_W'(HEADER_BYTES) + ADDR_W'(rem_q);
        seg_q    <= (ADDR_W'(room) > rem_len_q) ? rem_len_q[BS_W-1:0] : room;
      end
      S_OUT: begin
        if (out_free) begin
          rem_len_q <= rem_len_q - ADDR_W'(seg_q);
          rem_q     <= '0;
          blk_q     <= blk_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      status_q      <= res_status;
      zero_fill_q   <= res_zero_fill;
      file_offset_q <= res_file_offset;
      seg_len_q     <= res_seg_len;
      last_q        <= (state_q != S_OUT) || seg_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign zero_fill_o      = zero_fill_q;
  assign file_offset_o    = file_offset_q;
  assign segment_length_o = seg_len_q;
  assign last_o           = last_q;

`include "sparse_block_map_translator_assert.svh"

  `SBMT_ASSERT_SAME(a_err_is_last, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), last_o, "error result without last")
  `SBMT_ASSERT_SAME(a_err_empty, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), (file_offset_o == '0) && (segment_length_o == '0) && !zero_fill_o, "error result carries data")
  `SBMT_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (opcode_i == OP_READ), in_stall_o, "read item did not make the block busy")

endmodule
